### hw/rtl/csvfs_pkg.sv
// Types and constants shared by the CSV field splitter.
package csvfs_pkg;

	// Kind codes of a result word
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_FIELD  = 2'd1;
	localparam logic [1:0] KIND_RECORD = 2'd2;

	localparam logic [7:0] ASCII_LF = 8'h0A;
	localparam logic [7:0] ASCII_CR = 8'h0D;

	localparam logic [31:0] SEP_RESET   = 32'd44;
	localparam logic [31:0] QUOTE_RESET = 32'd34;
	localparam logic [2:0]  LEN_RESET   = 3'd1;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_SEP_BYTES = 2'd0;
	localparam logic [1:0] REG_SEP_LEN   = 2'd1;
	localparam logic [1:0] REG_QT_BYTES  = 2'd2;
	localparam logic [1:0] REG_QT_LEN    = 2'd3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [7:0] field_byte;
		logic [1:0] kind;
		logic       last_of_run;
	} token_word_t;

endpackage

### hw/rtl/csv_field_splitter_top.sv
// CSV field splitter: lookahead window, parser and result register.
//
// Text words enter on text_valid/text_stall, one byte each (or a bare word
// with byte_present low); end_of_text flushes the document. Result words
// leave on token_valid/token_stall: a field byte, an end-of-field mark or an
// end-of-record mark, with last_of_run on the final result of a text word.
// Separator and quote sequences are set through the APB port.
//
// Each cycle the parser takes one decision on the window head and produces
// at most one result word. A decision that only moves the parse state (start
// of a plain field, opening or closing quote) gives no result, and a result
// that trails a decision (end-of-record after end-of-field, the further bytes
// of a doubled quote) follows that decision on its own. Plain text runs at
// one byte per cycle while the receiver does not stall. Result words are
// held in the result register before they reach token_valid. A new text word
// is taken only after the previous one has finished its last decision and
// its trailing results, and not while the receiver stalls a held result.
// Reset clears the window fill, the parse state and the result valid and
// loads the default separator (comma) and quote (double quote). While the
// receiver stalls, the result register holds and the parser pauses.
module csv_field_splitter_top import csvfs_pkg::*; #(
	parameter int MAX_DELIM_BYTES = 4,
	parameter int WINDOW_BYTES    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  text_word_t  text_data,
	output logic        token_valid,
	input  logic        token_stall,
	output token_word_t token_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WIN_W = 8 * WINDOW_BYTES;
	localparam int FW    = $clog2(WINDOW_BYTES + 1);

	typedef enum logic [1:0] {MODE_START, MODE_PLAIN, MODE_QUOTED} mode_t;
	typedef enum logic [1:0] {SUB_NONE, SUB_REC, SUB_QB, SUB_FREC} sub_t;

	logic [31:0] sep_bytes_q, qt_bytes_q;
	logic [2:0]  sep_len_q, qt_len_q;

	logic [WIN_W-1:0] win_q;
	logic [FW-1:0]    fill_q;
	mode_t            mode_q;
	logic             asep_q;
	logic             end_q;
	logic             more_q;
	sub_t             sub_q;
	logic [2:0]       qcnt_q;
	logic             out_v_q;
	token_word_t      out_q;

	logic [2:0] s_eff, q_eff;
	logic       go, accept, step;

	logic [WIN_W-1:0] w_win, n_win;
	logic [FW-1:0]    w_fill, n_fill;
	logic             w_end;
	mode_t            n_mode;
	logic             n_asep;
	sub_t             n_sub;
	logic [2:0]       n_cnt;
	logic             res_v, more_n;
	logic [1:0]       res_kind;
	logic [7:0]       res_byte;
	logic [7:0]       b0, b1;
	logic             head_eol, m0q, mqq, m0s;
	logic [3:0]       eol_k;

	logic [WIN_W-1:0] y_win;
	logic [FW-1:0]    y_fill;
	logic             x_eol, x_q0, x_qq, y_q0, y_qq, x_yield, res_more;

	function automatic logic [2:0] eff_len(logic [2:0] v);
		logic [2:0] r;
		r = v;
		if (v == 3'd0) r = 3'd1;
		else if (v > 3'(MAX_DELIM_BYTES)) r = 3'(MAX_DELIM_BYTES);
		return r;
	endfunction

	function automatic logic [3:0] need_of(mode_t m, logic [2:0] s, logic [2:0] q);
		logic [3:0] n;
		if (m == MODE_QUOTED) begin
			n = {q, 1'b0};
		end else begin
			n = (4'(s) > 4'd2) ? 4'(s) : 4'd2;
			if (m != MODE_PLAIN && 4'(q) > n) n = 4'(q);
		end
		if (n > 4'(WINDOW_BYTES)) n = 4'(WINDOW_BYTES);
		return n;
	endfunction

	function automatic logic can_act(logic [FW-1:0] f, mode_t m, logic e,
			logic [2:0] s, logic [2:0] q);
		return (f != '0) && (e || (4'(f) >= need_of(m, s, q)));
	endfunction

	// sequence compare at a window offset; bytes beyond the fill mismatch
	function automatic logic match_at(logic [WIN_W-1:0] w, logic [FW-1:0] f,
			logic [31:0] seq, logic [2:0] len, logic [2:0] off);
		logic       ok;
		logic [3:0] idx;
		ok = (4'(off) + 4'(len)) <= 4'(f);
		for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
			idx = 4'(off) + 4'(i);
			if (3'(i) < len && 8'(w >> {idx, 3'b000}) != 8'(seq >> (8 * i))) ok = 1'b0;
		end
		return ok;
	endfunction

	// quoted mode without end of text: only a closing quote gives no word,
	// and the plain byte after it may still be waiting for lookahead
	function automatic logic quoted_yields(logic [FW-1:0] f, logic q0, logic qq,
			logic [2:0] s, logic [2:0] q);
		if (!can_act(f, MODE_QUOTED, 1'b0, s, q)) return 1'b0;
		if (q0 && !qq) return can_act(f - FW'(q), MODE_PLAIN, 1'b0, s, q);
		return 1'b1;
	endfunction

	assign s_eff  = eff_len(sep_len_q);
	assign q_eff  = eff_len(qt_len_q);
	assign go     = !out_v_q || !token_stall;
	assign text_stall = !(go && !more_q);
	assign accept = text_valid && !text_stall;
	assign step   = go && (accept || more_q);

	// working view: window with the new byte appended when a word is taken
	always_comb begin
		w_win  = win_q;
		w_fill = fill_q;
		w_end  = end_q;
		if (accept) begin
			w_end = text_data.end_of_text;
			if (text_data.byte_present && fill_q < FW'(WINDOW_BYTES)) begin
				for (int j = 0; j < WINDOW_BYTES; j++) begin
					if (FW'(j) == fill_q) w_win[8*j +: 8] = text_data.text_byte;
				end
				w_fill = fill_q + FW'(1);
			end
		end
	end

	assign b0       = w_win[7:0];
	assign b1       = 8'(w_win >> 8);
	assign head_eol = (w_fill != '0) && (b0 == ASCII_LF || b0 == ASCII_CR);
	assign m0q      = match_at(w_win, w_fill, qt_bytes_q, q_eff, 3'd0);
	assign mqq      = match_at(w_win, w_fill, qt_bytes_q, q_eff, q_eff);
	assign m0s      = match_at(w_win, w_fill, sep_bytes_q, s_eff, 3'd0);
	assign eol_k    = (b0 == ASCII_CR && w_fill >= FW'(2) && b1 == ASCII_LF) ? 4'd2 : 4'd1;

	always_comb begin
		n_win    = w_win;
		n_fill   = w_fill;
		n_mode   = mode_q;
		n_asep   = asep_q;
		n_sub    = sub_q;
		n_cnt    = qcnt_q;
		res_v    = 1'b0;
		res_kind = KIND_BYTE;
		res_byte = 8'd0;
		if (sub_q != SUB_NONE) begin
			res_v = 1'b1;
			case (sub_q)
				SUB_QB: begin
					res_byte = 8'(qt_bytes_q >> {qcnt_q, 3'b000});
					n_cnt    = qcnt_q + 3'd1;
					if (qcnt_q + 3'd1 == q_eff) n_sub = SUB_NONE;
				end
				default: begin
					res_kind = KIND_RECORD;
					n_sub    = SUB_NONE;
				end
			endcase
		end else if (can_act(w_fill, mode_q, w_end, s_eff, q_eff)) begin
			case (mode_q)
				MODE_START: begin
					if (head_eol) begin
						res_v    = 1'b1;
						res_kind = asep_q ? KIND_FIELD : KIND_RECORD;
						if (asep_q) n_sub = SUB_REC;
						n_win  = w_win >> {eol_k, 3'b000};
						n_fill = w_fill - FW'(eol_k);
						n_asep = 1'b0;
					end else if (m0q) begin
						n_win  = w_win >> {q_eff, 3'b000};
						n_fill = w_fill - FW'(q_eff);
						n_mode = MODE_QUOTED;
					end else begin
						n_mode = MODE_PLAIN;
					end
				end
				MODE_QUOTED: begin
					if (m0q && mqq) begin
						// doubled quote: emit one copy, the rest byte by byte
						res_v    = 1'b1;
						res_byte = b0;
						n_win    = w_win >> {q_eff, 4'b0000};
						n_fill   = w_fill - FW'({q_eff, 1'b0});
						if (q_eff != 3'd1) begin
							n_sub = SUB_QB;
							n_cnt = 3'd1;
						end
					end else if (m0q) begin
						n_win  = w_win >> {q_eff, 3'b000};
						n_fill = w_fill - FW'(q_eff);
						n_mode = MODE_PLAIN;
					end else begin
						res_v    = 1'b1;
						res_byte = b0;
						n_win    = w_win >> 8;
						n_fill   = w_fill - FW'(1);
					end
				end
				default: begin
					if (m0s || head_eol) begin
						res_v    = 1'b1;
						res_kind = KIND_FIELD;
						n_mode   = MODE_START;
						if (m0s) begin
							n_win  = w_win >> {s_eff, 3'b000};
							n_fill = w_fill - FW'(s_eff);
							n_asep = 1'b1;
						end else begin
							n_win  = w_win >> {eol_k, 3'b000};
							n_fill = w_fill - FW'(eol_k);
							n_asep = 1'b0;
							n_sub  = SUB_REC;
						end
					end else begin
						res_v    = 1'b1;
						res_byte = b0;
						n_win    = w_win >> 8;
						n_fill   = w_fill - FW'(1);
					end
				end
			endcase
		end else if (w_end) begin
			if (mode_q != MODE_START || asep_q) begin
				res_v    = 1'b1;
				res_kind = KIND_FIELD;
				n_sub    = SUB_FREC;
			end
			n_mode = MODE_START;
			n_asep = 1'b0;
			n_fill = '0;
		end
		more_n = (n_sub != SUB_NONE) || can_act(n_fill, n_mode, w_end, s_eff, q_eff) ||
			(w_end && (n_mode != MODE_START || n_asep));
	end

	// look past decisions that give no word to see whether this word is the last
	assign x_eol  = (n_fill != '0) && (n_win[7:0] == ASCII_LF || n_win[7:0] == ASCII_CR);
	assign x_q0   = match_at(n_win, n_fill, qt_bytes_q, q_eff, 3'd0);
	assign x_qq   = match_at(n_win, n_fill, qt_bytes_q, q_eff, q_eff);
	assign y_win  = n_win >> {q_eff, 3'b000};
	assign y_fill = n_fill - FW'(q_eff);
	assign y_q0   = match_at(y_win, y_fill, qt_bytes_q, q_eff, 3'd0);
	assign y_qq   = match_at(y_win, y_fill, qt_bytes_q, q_eff, q_eff);

	always_comb begin
		case (n_mode)
			MODE_START: x_yield = can_act(n_fill, MODE_START, 1'b0, s_eff, q_eff) &&
				(x_eol || !x_q0 || quoted_yields(y_fill, y_q0, y_qq, s_eff, q_eff));
			MODE_QUOTED: x_yield = quoted_yields(n_fill, x_q0, x_qq, s_eff, q_eff);
			default: x_yield = can_act(n_fill, MODE_PLAIN, 1'b0, s_eff, q_eff);
		endcase
		// with end of text every pending decision leads to a word
		res_more = w_end ? more_n : ((n_sub != SUB_NONE) || x_yield);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_bytes_q <= SEP_RESET;
			sep_len_q   <= LEN_RESET;
			qt_bytes_q  <= QUOTE_RESET;
			qt_len_q    <= LEN_RESET;
			fill_q      <= '0;
			mode_q      <= MODE_START;
			asep_q      <= 1'b0;
			end_q       <= 1'b0;
			more_q      <= 1'b0;
			sub_q       <= SUB_NONE;
			qcnt_q      <= 3'd0;
			out_v_q     <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_SEP_BYTES: sep_bytes_q <= pwdata;
					REG_SEP_LEN:   sep_len_q   <= pwdata[2:0];
					REG_QT_BYTES:  qt_bytes_q  <= pwdata;
					REG_QT_LEN:    qt_len_q    <= pwdata[2:0];
					default: ;
				endcase
			end
			if (go) out_v_q <= step && res_v;
			if (step) begin
				fill_q <= n_fill;
				mode_q <= n_mode;
				asep_q <= n_asep;
				end_q  <= w_end;
				more_q <= more_n;
				sub_q  <= n_sub;
				qcnt_q <= n_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) win_q <= n_win;
		if (step && res_v) begin
			out_q.field_byte  <= res_byte;
			out_q.kind        <= res_kind;
			out_q.last_of_run <= !res_more;
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SEP_BYTES: prdata = sep_bytes_q;
			REG_SEP_LEN:   prdata = {29'd0, sep_len_q};
			REG_QT_BYTES:  prdata = qt_bytes_q;
			REG_QT_LEN:    prdata = {29'd0, qt_len_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign pready      = 1'b1;
	assign token_valid = out_v_q;
	assign token_data  = out_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_BYTES))
		else $error("window fill beyond window size");

	a_sub_needs_more: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q != SUB_NONE |-> more_q)
		else $error("pending result without pending work");

	a_qcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q == SUB_QB |-> (qcnt_q != 3'd0 && qcnt_q < q_eff))
		else $error("quote byte counter out of range");

	a_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_v && !more_n) |=> (token_valid && token_data.last_of_run && !more_q))
		else $error("final result not flagged last");
`endif

endmodule

### verif/csv_field_splitter_top_tb.sv
// Self-checking testbench for the CSV field splitter: directed documents, then random CSV text.
module csv_field_splitter_top_tb;
	import csvfs_pkg::*;

	localparam int WIN = 8;
	localparam int MAXD = 4;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_stall;
	text_word_t  text_data;
	logic        token_valid;
	logic        token_stall;
	token_word_t token_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	csv_field_splitter_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.text_valid(text_valid), .text_stall(text_stall), .text_data(text_data),
		.token_valid(token_valid), .token_stall(token_stall), .token_data(token_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef enum logic [1:0] {PM_START, PM_PLAIN, PM_QUOTED} parse_mode_t;

	// predictor state
	logic [31:0]  sep_seq, quote_seq;
	logic [2:0]   sep_len_reg, quote_len_reg;
	logic [7:0]   window [WIN];
	int           window_fill;
	parse_mode_t  mode;
	bit           trail_sep;
	token_word_t  step_tokens[$];
	token_word_t  expected_tokens[$];

	int  mismatches;
	int  tokens_seen;
	int  words_sent;
	int  idle_cycles;
	bit  text_idle_on, token_idle_on;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	function automatic int eff_len(logic [2:0] v);
		if (v == 3'd0) return 1;
		if (v > MAXD) return MAXD;
		return int'(v);
	endfunction

	function automatic bit seq_at(logic [31:0] seq, int len, int off);
		if (off + len > window_fill) return 1'b0;
		for (int i = 0; i < len; i++)
			if (window[off + i] != seq[8*i +: 8]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void shift_out(int k);
		if (k > window_fill) k = window_fill;
		for (int i = 0; i < WIN - k; i++) window[i] = window[i + k];
		window_fill -= k;
	endfunction

	function automatic void push_token(logic [1:0] k, logic [7:0] b);
		token_word_t t;
		if (step_tokens.size() >= 12) return;
		t.field_byte = b;
		t.kind = k;
		t.last_of_run = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function automatic int bytes_needed();
		int s, q, n;
		s = eff_len(sep_len_reg);
		q = eff_len(quote_len_reg);
		if (mode == PM_QUOTED) n = 2 * q;
		else begin
			n = s > 2 ? s : 2;
			if (mode != PM_PLAIN && q > n) n = q;
		end
		return n > WIN ? WIN : n;
	endfunction

	function automatic bit head_eol();
		return window_fill > 0 && (window[0] == ASCII_LF || window[0] == ASCII_CR);
	endfunction

	function automatic void end_record();
		int k;
		k = 1;
		if (window[0] == ASCII_CR && window_fill >= 2 && window[1] == ASCII_LF) k = 2;
		push_token(KIND_RECORD, 8'h00);
		shift_out(k);
		mode = PM_START;
		trail_sep = 1'b0;
	endfunction

	function automatic void decide();
		int s, q;
		bit sep;
		s = eff_len(sep_len_reg);
		q = eff_len(quote_len_reg);
		case (mode)
			PM_START: begin
				if (head_eol()) begin
					if (trail_sep) push_token(KIND_FIELD, 8'h00);
					end_record();
				end else if (seq_at(quote_seq, q, 0)) begin
					shift_out(q);
					mode = PM_QUOTED;
				end else
					mode = PM_PLAIN;
			end
			PM_QUOTED: begin
				if (seq_at(quote_seq, q, 0)) begin
					if (seq_at(quote_seq, q, q)) begin
						for (int i = 0; i < q; i++) push_token(KIND_BYTE, window[i]);
						shift_out(2 * q);
					end else begin
						shift_out(q);
						mode = PM_PLAIN;
					end
				end else begin
					push_token(KIND_BYTE, window[0]);
					shift_out(1);
				end
			end
			default: begin
				sep = seq_at(sep_seq, s, 0);
				if (sep || head_eol()) begin
					push_token(KIND_FIELD, 8'h00);
					if (sep) begin
						shift_out(s);
						mode = PM_START;
						trail_sep = 1'b1;
					end else
						end_record();
				end else begin
					push_token(KIND_BYTE, window[0]);
					shift_out(1);
				end
			end
		endcase
	endfunction

	function automatic void predict_word(text_word_t w);
		int guard;
		guard = 0;
		step_tokens.delete();
		if (w.byte_present && window_fill < WIN) begin
			window[window_fill] = w.text_byte;
			window_fill++;
		end
		while (window_fill > 0 && (w.end_of_text || window_fill >= bytes_needed())
				&& guard < 4 * WIN + 4) begin
			decide();
			guard++;
		end
		if (w.end_of_text) begin
			if (mode != PM_START || trail_sep) begin
				push_token(KIND_FIELD, 8'h00);
				push_token(KIND_RECORD, 8'h00);
			end
			mode = PM_START;
			trail_sep = 1'b0;
			window_fill = 0;
		end
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
		foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
	endfunction

	// token checker
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token word: byte %h kind %0d last %0b",
						token_data.field_byte, token_data.kind, token_data.last_of_run);
			end else begin
				token_word_t e;
				e = expected_tokens.pop_front();
				if (e !== token_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"token mismatch: exp byte %h kind %0d last %0b, ",
							"got byte %h kind %0d last %0b"},
							e.field_byte, e.kind, e.last_of_run,
							token_data.field_byte, token_data.kind, token_data.last_of_run);
				end
			end
		end
	end

	// receiver stalls in bursts
	int token_burst;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_stall <= 1'b0;
			token_burst = 0;
		end else if (token_burst > 0) begin
			token_burst--;
			if (token_burst == 0) token_stall <= 1'b0;
		end else if (token_idle_on && $urandom_range(0, 5) == 0) begin
			token_burst = $urandom_range(1, 8);
			token_stall <= 1'b1;
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (token_valid && !token_stall) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SEP_BYTES: sep_seq = value;
			REG_SEP_LEN:   sep_len_reg = value[2:0];
			REG_QT_BYTES:  quote_seq = value;
			default:       quote_len_reg = value[2:0];
		endcase
	endtask

	// waits for the block to drain, then a margin for trailing decisions
	task automatic wait_idle();
		text_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_delims(logic [31:0] sb, logic [2:0] sl, logic [31:0] qb, logic [2:0] ql);
		wait_idle();
		reg_write(REG_SEP_BYTES, sb);
		reg_write(REG_SEP_LEN, {29'd0, sl});
		reg_write(REG_QT_BYTES, qb);
		reg_write(REG_QT_LEN, {29'd0, ql});
	endtask

	// sends one text word, with an optional idle gap first; valid stays high
	// afterwards so that words can follow back to back
	task automatic send_word(logic [7:0] b, bit present, bit last);
		text_word_t w;
		w.text_byte = b;
		w.byte_present = present;
		w.end_of_text = last;
		if (text_idle_on && $urandom_range(0, 5) == 0) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_data <= w;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		predict_word(w);
		words_sent++;
	endtask

	task automatic send_text(string s, bit finish_doc);
		for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, 1'b0);
		if (finish_doc) send_word(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_directed_defaults();
		send_word(8'h00, 1'b0, 1'b1);                 // end with no text
		send_text("a,\"b\"\"c\"x,\r\n\n", 1'b0);
		send_word(8'h00, 1'b0, 1'b0);                 // bare word
		send_word(8'hff, 1'b1, 1'b0);                 // top byte value
		send_text(",", 1'b1);                          // trailing separator
		send_text("\"open\rq", 1'b0);
		send_word(8'h80, 1'b1, 1'b1);                 // unterminated quote, end with byte
		send_text("\r", 1'b1);
	endtask

	task automatic test_long_delims();
		set_delims(32'h3a3a3a3a, 3'd4, 32'h27272727, 3'd4);
		send_text("ab::::''''x''''''''y''''::\n", 1'b1);
		set_delims(32'h0000_0a3b, 3'd0, 32'h0000_0d22, 3'd7); // length extremes, overlap with EOL
		send_text(";\"x\r;\n", 1'b1);
	endtask

	function automatic logic [7:0] pick_byte(logic [31:0] sb, logic [31:0] qb);
		case ($urandom_range(0, 9))
			0:       return sb[8*$urandom_range(0, 3) +: 8];
			1:       return qb[8*$urandom_range(0, 3) +: 8];
			2:       return $urandom_range(0, 1) ? ASCII_CR : ASCII_LF;
			3:       return 8'($urandom);
			default: return 8'($urandom_range(8'h61, 8'h7a));
		endcase
	endfunction

	task automatic test_random_text(int budget, bit quiet);
		logic [31:0] sb, qb;
		logic [2:0]  sl, ql;
		int start, groups;
		start = words_sent;
		while (words_sent - start < budget) begin
			sb = $urandom;
			qb = $urandom;
			sl = 3'($urandom_range(0, 7));
			ql = 3'($urandom_range(0, 7));
			if ($urandom_range(0, 2) == 0) begin
				sb = SEP_RESET;
				qb = QUOTE_RESET;
				sl = LEN_RESET;
				ql = LEN_RESET;
			end
			text_idle_on = !quiet;
			token_idle_on = !quiet;
			set_delims(sb, sl, qb, ql);
			groups = $urandom_range(20, 60);
			for (int g = 0; g < groups && words_sent - start < budget; g++) begin
				// mostly well-formed fragments: delimiters whole, plus noise
				case ($urandom_range(0, 4))
					0: for (int i = 0; i < eff_len(sl); i++) send_word(sb[8*i +: 8], 1'b1, 1'b0);
					1: for (int i = 0; i < eff_len(ql); i++) send_word(qb[8*i +: 8], 1'b1, 1'b0);
					2: send_word(pick_byte(sb, qb), $urandom_range(0, 7) != 0, 1'b0);
					default: send_word(8'($urandom_range(8'h30, 8'h7a)), 1'b1, 1'b0);
				endcase
			end
			send_word(pick_byte(sb, qb), 1'($urandom_range(0, 1)), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sep_seq = SEP_RESET;
		quote_seq = QUOTE_RESET;
		sep_len_reg = LEN_RESET;
		quote_len_reg = LEN_RESET;
		window_fill = 0;
		mode = PM_START;
		trail_sep = 1'b0;
		mismatches = 0;
		tokens_seen = 0;
		words_sent = 0;
		idle_cycles = 0;
		text_idle_on = 1'b1;
		token_idle_on = 1'b1;
		foreach (window[i]) window[i] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_long_delims();
		test_random_text(320, 1'b0);
		test_random_text(80, 1'b1);
		wait_idle();
		$display("covered %0d text words and %0d token words over several delimiter settings",
			words_sent, tokens_seen);
		$display("%0d mismatches", mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
